// ===== sv/rcm_pkg.sv =====
// shared types, constants and helpers of the rssi change monitor
package rcm_pkg;

    localparam int WINDOW_DEPTH = 10;
    localparam int LAG_DEPTH    = 25;

    localparam int RSSI_W = 8;
    localparam int WS_W   = 12;
    localparam int THR_W  = 11;
    localparam int HOLD_W = 7;

    // kalman fixed point: estimate q8.16, variance q4.20, gain q0.20
    localparam int EST_W  = 24;
    localparam int VAR_W  = 24;
    localparam int KG_W   = 20;
    localparam int DEN_W  = VAR_W + 1;
    localparam int DIFF_W = EST_W + 1;

    localparam logic [VAR_W-1:0] KF_Q        = 24'd10486;
    localparam logic [VAR_W-1:0] KF_R        = 24'd209715;
    localparam logic [VAR_W-1:0] VAR_MAX     = 24'hFFFFFF;
    localparam logic [VAR_W-1:0] VAR_RESET   = 24'hA00000;
    localparam logic [KG_W:0]    KF_ONE      = 21'h100000;
    localparam logic [DEN_W-1:0] KF_QR       = 25'd220201;
    localparam logic [DEN_W-1:0] DEN_MAX     = 25'd16986930;

    localparam logic [HOLD_W-1:0] HOLD_LIMIT = 7'd127;
    localparam logic [HOLD_W-1:0] HOLD_START = 7'd1;

    localparam int WIN_AW  = $clog2(WINDOW_DEPTH);
    localparam int LAG_AW  = $clog2(LAG_DEPTH);
    localparam int SUM_W   = $clog2(WINDOW_DEPTH * 128) + 1;
    localparam int DIF_W   = SUM_W + 1;
    localparam int TRI_W   = (DIF_W + 2 > THR_W + 1) ? DIF_W + 2 : THR_W + 1;
    localparam int DEC_W   = ((DIF_W > THR_W + 1) ? DIF_W : THR_W + 1) + 8;

    typedef logic signed [RSSI_W-1:0] rssi_t;
    typedef logic signed [WS_W-1:0]   wsum_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [THR_W-1:0]         thr_t;
    typedef logic [HOLD_W-1:0]        hold_t;
    typedef logic [0:0]               cfg_idx_t;
    typedef logic [THR_W-1:0]         cfg_data_t;

    localparam cfg_idx_t CFG_SWITCH_THRESHOLD = 1'b0;
    localparam cfg_idx_t CFG_HOLD_COUNT       = 1'b1;

    localparam thr_t  THR_RESET  = 11'd35;
    localparam hold_t HOLD_RESET = 7'd60;

    function automatic wsum_t sat_wsum(input sum_t s);
        int v;
        v = int'(s);
        if (v > 2047)
            v = 2047;
        else if (v < -2048)
            v = -2048;
        return v[WS_W-1:0];
    endfunction

endpackage

// ===== sv/rcm_channels.sv =====
// valid/ready channels for rssi samples and monitor results
interface rcm_sample_if;
    import rcm_pkg::*;
    logic  valid;
    logic  ready;
    rssi_t rssi_sample;

    modport source (output valid, output rssi_sample, input ready);
    modport sink (input valid, input rssi_sample, output ready);
endinterface

interface rcm_result_if;
    import rcm_pkg::*;
    logic  valid;
    logic  ready;
    rssi_t filtered_rssi;
    wsum_t window_sum;
    logic  watching;
    logic  reselect_request;

    modport source (output valid, output filtered_rssi, output window_sum,
                    output watching, output reselect_request, input ready);
    modport sink (input valid, input filtered_rssi, input window_sum,
                  input watching, input reselect_request, output ready);
endinterface

// ===== sv/rssi_change_monitor.sv =====
// rssi change monitor: kalman smoothing, sliding window sum, lag line and reselect decision
//
// One sample is worked on at a time. An item goes from acceptance to the result register
// through the 20-step restoring divider that forms the kalman gain, the gain and variance
// multiplies, the update, rounding, the window memory step and, once the window is full,
// the lag memory step and, once the lag line is full, the decision. The next sample is
// taken in the cycle after the result is loaded, even if that result is not yet taken.
// The result step waits while the previous result is still held. Window samples and
// lagged sums live in two synchronous memories read once per item.
module rssi_change_monitor (
    input  logic                 clk,
    input  logic                 rst_n,
    rcm_sample_if.sink           sample,
    rcm_result_if.source         result,
    input  logic                 cfg_we,
    input  rcm_pkg::cfg_idx_t    cfg_index,
    input  rcm_pkg::cfg_data_t   cfg_data
);
    import rcm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_GAIN,
        ST_MUL_VAR,
        ST_UPDATE,
        ST_ROUND,
        ST_WINDOW,
        ST_LAG,
        ST_JUDGE,
        ST_EMIT
    } state_t;

    localparam int DIV_CW = $clog2(KG_W);
    localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(KG_W - 1);
    localparam logic [WIN_AW-1:0] WIN_LAST = WIN_AW'(WINDOW_DEPTH - 1);
    localparam logic [LAG_AW-1:0] LAG_LAST = LAG_AW'(LAG_DEPTH - 1);

    state_t state_reg;

    // configuration
    thr_t  thr_reg;
    hold_t hold_cnt_reg;

    // kalman state and datapath
    logic signed [EST_W-1:0]  estimate_reg;
    logic [VAR_W-1:0]         var_reg;
    logic [VAR_W-1:0]         p_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [DEN_W-1:0]         rem_reg;
    logic [KG_W-1:0]          kg_reg;
    logic [DIV_CW-1:0]        div_cnt_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [KG_W:0]            gain_cmp_reg;
    logic signed [KG_W+DIFF_W:0] prod1_reg;
    logic [KG_W+VAR_W:0]      prod2_reg;
    rssi_t                    f_reg;

    // window and lag state
    logic [WIN_AW-1:0] win_head_reg;
    logic [WIN_AW-1:0] win_count_reg;
    sum_t              sum_reg;
    logic [LAG_AW-1:0] lag_head_reg;
    logic [LAG_AW-1:0] lag_count_reg;
    sum_t              saved_reg;
    sum_t              last_reg;
    hold_t             hold_reg;
    logic [DIF_W-1:0]  jump_reg;
    logic [DIF_W-1:0]  asaved_reg;
    logic              resel_reg;

    // result register
    logic  out_valid_reg;
    rssi_t out_f_reg;
    wsum_t out_ws_reg;
    logic  out_watch_reg;
    logic  out_resel_reg;

    // memories
    rssi_t win_mem [WINDOW_DEPTH];
    sum_t  lag_mem [LAG_DEPTH];
    rssi_t win_rdata_reg;
    sum_t  lag_rdata_reg;

    logic accept;
    logic win_we;
    logic lag_we;
    logic [WIN_AW-1:0] win_waddr;
    logic [LAG_AW-1:0] lag_waddr;
    logic [WIN_AW:0]   win_wsum;
    logic [LAG_AW:0]   lag_wsum;

    // kalman combinational terms
    logic [DEN_W-1:0]         p_sum;
    logic [VAR_W-1:0]         p_sat;
    logic [DEN_W-1:0]         den_sum;
    logic [DEN_W-1:0]         den_sat;
    logic signed [DIFF_W-1:0] diff_c;
    logic [DEN_W:0]           rem2;
    logic                     rem_ge;
    logic [DEN_W:0]           rem_sub;
    logic signed [KG_W+DIFF_W:0] prod1_c;
    logic [KG_W+VAR_W:0]      prod2_c;
    logic signed [EST_W+2:0]  est_sum;
    logic signed [EST_W-1:0]  est_sat;
    logic signed [EST_W:0]    rv;
    logic signed [EST_W+1:0]  rt;
    logic signed [9:0]        rq;
    rssi_t                    f_c;

    // window, lag and decision terms
    logic              win_pop;
    sum_t              sum_win;
    logic              lag_pop;
    logic signed [DIF_W-1:0] jd;
    logic signed [DIF_W-1:0] ad;
    logic [DIF_W-1:0]  jump_c;
    logic [DIF_W-1:0]  asaved_c;
    logic [TRI_W-1:0]  jump3;
    logic [TRI_W-1:0]  thr2;
    logic              hit;
    hold_t             h1;
    hold_t             h2;
    logic              expire;
    logic [DIF_W-1:0]  a_sel;
    logic [DEC_W-1:0]  a100;
    logic [DEC_W-1:0]  bound;
    logic              resel_c;
    hold_t             hold_c;

    assign accept       = sample.valid && sample.ready;
    assign sample.ready = (state_reg == ST_IDLE);

    assign result.valid            = out_valid_reg;
    assign result.filtered_rssi    = out_f_reg;
    assign result.window_sum       = out_ws_reg;
    assign result.watching         = out_watch_reg;
    assign result.reselect_request = out_resel_reg;

    // gain numerator and denominator
    assign p_sum   = {1'b0, var_reg} + {1'b0, KF_Q};
    assign p_sat   = p_sum[DEN_W-1] ? VAR_MAX : p_sum[VAR_W-1:0];
    assign den_sum = {1'b0, var_reg} + KF_QR;
    assign den_sat = p_sum[DEN_W-1] ? DEN_MAX : den_sum;
    assign diff_c  = {sample.rssi_sample[RSSI_W-1], sample.rssi_sample, 16'b0}
                     - {estimate_reg[EST_W-1], estimate_reg};

    // restoring divider step
    assign rem2    = {rem_reg, 1'b0};
    assign rem_ge  = rem2 >= {1'b0, den_reg};
    assign rem_sub = rem2 - {1'b0, den_reg};

    assign prod1_c = $signed({1'b0, kg_reg}) * diff_reg;
    assign prod2_c = gain_cmp_reg * p_reg;

    always_comb
    begin
        est_sum = {{3{estimate_reg[EST_W-1]}}, estimate_reg}
                  + {prod1_reg[KG_W+DIFF_W], prod1_reg[KG_W+DIFF_W:KG_W]};
        if (est_sum > $signed(27'sd8388607))
            est_sat = 24'sh7FFFFF;
        else if (est_sum < $signed(-27'sd8388608))
            est_sat = 24'sh800000;
        else
            est_sat = est_sum[EST_W-1:0];
    end

    // add one half, truncate toward zero, saturate
    always_comb
    begin
        rv = {estimate_reg[EST_W-1], estimate_reg} + 25'sd32768;
        rt = {rv[EST_W], rv} + (rv[EST_W] ? 26'sd65535 : 26'sd0);
        rq = rt[EST_W+1:16];
        if (rq > 10'sd127)
            f_c = 8'sd127;
        else if (rq < -10'sd128)
            f_c = -8'sd128;
        else
            f_c = rq[RSSI_W-1:0];
    end

    // window memory step
    assign win_pop  = (win_count_reg == WIN_LAST);
    assign sum_win  = sum_reg + {{(SUM_W-RSSI_W){f_reg[RSSI_W-1]}}, f_reg}
                      - (win_pop ? {{(SUM_W-RSSI_W){win_rdata_reg[RSSI_W-1]}}, win_rdata_reg}
                                 : SUM_W'(0));
    assign win_wsum  = {1'b0, win_head_reg} + {1'b0, win_count_reg};
    assign win_waddr = (win_wsum >= (WIN_AW+1)'(WINDOW_DEPTH))
                       ? WIN_AW'(win_wsum - (WIN_AW+1)'(WINDOW_DEPTH))
                       : win_wsum[WIN_AW-1:0];
    assign win_we    = (state_reg == ST_WINDOW);

    // lag memory step
    assign lag_pop   = (lag_count_reg == LAG_LAST);
    assign lag_wsum  = {1'b0, lag_head_reg} + {1'b0, lag_count_reg};
    assign lag_waddr = (lag_wsum >= (LAG_AW+1)'(LAG_DEPTH))
                       ? LAG_AW'(lag_wsum - (LAG_AW+1)'(LAG_DEPTH))
                       : lag_wsum[LAG_AW-1:0];
    assign lag_we    = (state_reg == ST_LAG);

    assign jd       = {lag_rdata_reg[SUM_W-1], lag_rdata_reg} - {sum_reg[SUM_W-1], sum_reg};
    assign ad       = {saved_reg[SUM_W-1], saved_reg} - {sum_reg[SUM_W-1], sum_reg};
    assign jump_c   = jd[DIF_W-1] ? DIF_W'(-jd) : DIF_W'(jd);
    assign asaved_c = ad[DIF_W-1] ? DIF_W'(-ad) : DIF_W'(ad);

    // jump, hold and reselect decision
    always_comb
    begin
        jump3   = TRI_W'(jump_reg) + TRI_W'({jump_reg, 1'b0});
        thr2    = TRI_W'({thr_reg, 1'b0});
        hit     = (jump3 > thr2) && (hold_reg == '0);
        h1      = hit ? HOLD_START : hold_reg;
        h2      = (h1 < HOLD_LIMIT) ? h1 + HOLD_START : h1;
        expire  = (h2 > hold_cnt_reg) || (h2 == HOLD_LIMIT);
        a_sel   = hit ? jump_reg : asaved_reg;
        a100    = DEC_W'(a_sel) * DEC_W'(100);
        bound   = DEC_W'(jump_reg) + DEC_W'({1'b0, thr_reg} + 12'd1) * DEC_W'(100);
        resel_c = 1'b0;
        hold_c  = hold_reg;
        if (h1 != '0)
        begin
            hold_c = h2;
            if (expire)
            begin
                hold_c  = '0;
                resel_c = (a100 >= bound);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_we)
            win_mem[win_waddr] <= f_reg;
        if (accept)
            win_rdata_reg <= win_mem[win_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (lag_we)
            lag_mem[lag_waddr] <= sum_reg;
        if (accept)
            lag_rdata_reg <= lag_mem[lag_head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= THR_RESET;
            hold_cnt_reg <= HOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SWITCH_THRESHOLD: thr_reg      <= cfg_data;
                CFG_HOLD_COUNT:       hold_cnt_reg <= cfg_data[HOLD_W-1:0];
                default:              thr_reg      <= thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            estimate_reg  <= '0;
            var_reg       <= VAR_RESET;
            p_reg         <= '0;
            den_reg       <= '0;
            rem_reg       <= '0;
            kg_reg        <= '0;
            div_cnt_reg   <= '0;
            diff_reg      <= '0;
            gain_cmp_reg  <= '0;
            prod1_reg     <= '0;
            prod2_reg     <= '0;
            f_reg         <= '0;
            win_head_reg  <= '0;
            win_count_reg <= '0;
            sum_reg       <= '0;
            lag_head_reg  <= '0;
            lag_count_reg <= '0;
            saved_reg     <= '0;
            last_reg      <= '0;
            hold_reg      <= '0;
            jump_reg      <= '0;
            asaved_reg    <= '0;
            resel_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_f_reg     <= '0;
            out_ws_reg    <= '0;
            out_watch_reg <= 1'b0;
            out_resel_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && result.ready && state_reg != ST_EMIT)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        p_reg       <= p_sat;
                        den_reg     <= den_sat;
                        rem_reg     <= {1'b0, p_sat};
                        kg_reg      <= '0;
                        div_cnt_reg <= '0;
                        diff_reg    <= diff_c;
                        resel_reg   <= 1'b0;
                        state_reg   <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_reg     <= rem_ge ? rem_sub[DEN_W-1:0] : rem2[DEN_W-1:0];
                    kg_reg      <= {kg_reg[KG_W-2:0], rem_ge};
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DIV_LAST)
                        state_reg <= ST_MUL_GAIN;
                end
                ST_MUL_GAIN:
                begin
                    prod1_reg    <= prod1_c;
                    gain_cmp_reg <= KF_ONE - {1'b0, kg_reg};
                    state_reg    <= ST_MUL_VAR;
                end
                ST_MUL_VAR:
                begin
                    prod2_reg <= prod2_c;
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    estimate_reg <= est_sat;
                    var_reg      <= prod2_reg[KG_W+VAR_W-1:KG_W];
                    state_reg    <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    f_reg     <= f_c;
                    state_reg <= ST_WINDOW;
                end
                ST_WINDOW:
                begin
                    sum_reg <= sum_win;
                    if (win_pop)
                    begin
                        win_head_reg <= (win_head_reg == WIN_LAST) ? '0 : win_head_reg + 1'b1;
                        state_reg    <= ST_LAG;
                    end
                    else
                    begin
                        win_count_reg <= win_count_reg + 1'b1;
                        state_reg     <= ST_EMIT;
                    end
                end
                ST_LAG:
                begin
                    if (lag_pop)
                    begin
                        lag_head_reg <= (lag_head_reg == LAG_LAST) ? '0 : lag_head_reg + 1'b1;
                        last_reg     <= lag_rdata_reg;
                        jump_reg     <= jump_c;
                        asaved_reg   <= asaved_c;
                        state_reg    <= ST_JUDGE;
                    end
                    else
                    begin
                        lag_count_reg <= lag_count_reg + 1'b1;
                        state_reg     <= ST_EMIT;
                    end
                end
                ST_JUDGE:
                begin
                    hold_reg  <= hold_c;
                    resel_reg <= resel_c;
                    if (hit)
                        saved_reg <= last_reg;
                    if (resel_c)
                    begin
                        win_count_reg <= '0;
                        lag_count_reg <= '0;
                        sum_reg       <= '0;
                    end
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_f_reg     <= f_reg;
                        out_ws_reg    <= sat_wsum(sum_reg);
                        out_watch_reg <= (hold_reg != '0);
                        out_resel_reg <= resel_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
